// ===== hw/rtl/pf_pkg.sv =====
// Shared types and constants for the polyline path follower.
// No dependencies; imported by the top module, pf_isqrt and pf_div.
package pf_pkg;

    localparam int LNG_W  = 31;
    localparam int LAT_W  = 30;
    localparam int STEP_W = 40;

    // Input beat kinds carried on tuser.
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_TICK   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_SPEED     = 1'b0;
    localparam logic REG_TIME_STEP = 1'b1;

    localparam logic [23:0] TIME_STEP_RESET = 24'h010000;

    typedef struct packed {
        logic signed [LNG_W-1:0] lng;
        logic signed [LAT_W-1:0] lat;
    } point_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_APPEND,
        ST_STEP,
        ST_STEP_W,
        ST_LOOP,
        ST_RD_A,
        ST_RD_B,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_R,
        ST_CMP,
        ST_SQRT,
        ST_ADV,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_HEAD,
        ST_HEAD_W
    } state_t;

    // Handshake of an iterative unit towards the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hw/rtl/polyline_path_follower_top.sv =====
// Polyline path follower: waypoint queue, sequencer and shared arithmetic units.
// Depends on pf_pkg, pf_mul, pf_isqrt and pf_div.
// The square root and divider are iterative units of 32 steps each. One beat is
// worked on at a time, and the input is ready again from the cycle in which the
// result is registered; a finished result waits in the output register while
// the next beat is taken.
// Reset (synchronous, active low) empties the queue and clears the arrived flag.
module polyline_path_follower_top
    import pf_pkg::*;
#(
    parameter int PATH_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // point_lng, point_lat
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // current_lng, current_lat, points_left,
                                        // arrived, overflow
);

    localparam int IDX_W = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t state_reg, state_next;

    logic [31:0]      speed_reg;
    logic [23:0]      tstep_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             arrived_reg, arrived_next;
    logic             m_valid_reg, m_valid_next;
    logic [71:0]      m_data_reg, m_data_next;

    logic [1:0]        mode_reg, mode_next;
    point_t            pt_reg, pt_next;
    point_t            a_reg, a_next;
    logic              ovf_reg, ovf_next;
    logic              xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic [31:0]       ux_reg, ux_next, uy_reg, uy_next;
    logic [63:0]       d2_reg, d2_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [31:0]       len_reg, len_next;
    logic              longer_reg, longer_next;
    logic [31:0]       qx_reg, qx_next;

    // Path store with one write and one registered read port.
    point_t           mem [PATH_DEPTH];
    point_t           rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    point_t           mem_wdata;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic        sqrt_start, div_start;
    logic [31:0] root, quot;
    unit_stat_t  sqrt_stat, div_stat;

    logic             accept;
    logic [IDX_W-1:0] head_inc, tail;
    logic [SUM_W-1:0] tail_sum;
    logic             full;
    logic signed [31:0] dx;
    logic signed [30:0] dy;
    logic [31:0] qx_s, qy_s, new_lng, new_lat;
    logic [CNT_W+6:0] cnt_ext;

    pf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pf_isqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (d2_reg),
        .root     (root),
        .stat     (sqrt_stat)
    );

    pf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (len_reg),
        .quotient (quot),
        .stat     (div_stat)
    );

    // Queue index arithmetic with wrap at the depth.
    assign head_inc = (head_reg == IDX_W'(PATH_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(PATH_DEPTH))
                    ? IDX_W'(tail_sum - SUM_W'(PATH_DEPTH)) : IDX_W'(tail_sum);
    assign full     = count_reg >= CNT_W'(PATH_DEPTH);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign cnt_ext  = {7'd0, count_reg};

    // Segment deltas from the start point and the end point just read.
    assign dx = {rdata_reg.lng[LNG_W-1], rdata_reg.lng} - {a_reg.lng[LNG_W-1], a_reg.lng};
    assign dy = {rdata_reg.lat[LAT_W-1], rdata_reg.lat} - {a_reg.lat[LAT_W-1], a_reg.lat};

    // Interpolated start point; the offset from the old start point is rounded towards zero on each axis.
    assign qx_s    = xneg_reg ? -qx_reg : qx_reg;
    assign qy_s    = yneg_reg ? -quot : quot;
    assign new_lng = {a_reg.lng[LNG_W-1], a_reg.lng} + qx_s;
    assign new_lat = {{2{a_reg.lat[LAT_W-1]}}, a_reg.lat} + qy_s;

    // Sequencer: next state, datapath updates and unit control.
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        arrived_next = arrived_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mode_next    = mode_reg;
        pt_next      = pt_reg;
        a_next       = a_reg;
        ovf_next     = ovf_reg;
        xneg_next    = xneg_reg;
        yneg_next    = yneg_reg;
        ux_next      = ux_reg;
        uy_next      = uy_reg;
        d2_next      = d2_reg;
        rem_next     = rem_reg;
        len_next     = len_reg;
        longer_next  = longer_reg;
        qx_next      = qx_reg;
        mem_we       = 1'b0;
        mem_waddr    = head_reg;
        mem_wdata    = a_reg;
        mem_raddr    = head_reg;
        mul_a        = ux_reg;
        mul_b        = ux_reg;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_axis_tuser;
                    pt_next    = '{lng: s_axis_tdata[30:0], lat: s_axis_tdata[60:31]};
                    ovf_next   = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (mode_reg)
                    MODE_APPEND: state_next = ST_APPEND;
                    MODE_TICK:   state_next = ST_STEP;
                    MODE_CLEAR: begin
                        head_next    = '0;
                        count_next   = '0;
                        arrived_next = 1'b0;
                        state_next   = ST_HEAD;
                    end
                    default:     state_next = ST_HEAD;
                endcase
            end
            ST_APPEND: begin
                if (full) begin
                    ovf_next = 1'b1;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = tail;
                    mem_wdata  = pt_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = ST_HEAD;
            end
            ST_STEP: begin
                mul_a      = speed_reg;
                mul_b      = {8'd0, tstep_reg};
                state_next = ST_STEP_W;
            end
            ST_STEP_W: begin
                rem_next   = prod[55:16];
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                if (count_reg < CNT_W'(2)) begin
                    arrived_next = 1'b1;
                    state_next   = ST_HEAD;
                end else begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: begin
                a_next     = rdata_reg;
                mem_raddr  = head_inc;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                xneg_next  = dx[31];
                yneg_next  = dy[30];
                ux_next    = dx[31] ? 32'(-dx) : 32'(dx);
                uy_next    = dy[30] ? 32'(-dy) : 32'(dy);
                state_next = ST_SQ_X;
            end
            ST_SQ_X: begin
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                d2_next    = prod;
                mul_a      = uy_reg;
                mul_b      = uy_reg;
                state_next = ST_SQ_R;
            end
            ST_SQ_R: begin
                d2_next    = d2_reg + prod;
                mul_a      = rem_reg[31:0];
                mul_b      = rem_reg[31:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                longer_next = (rem_reg[STEP_W-1:32] == '0) && (d2_reg > prod);
                sqrt_start  = 1'b1;
                state_next  = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_stat.done) begin
                    len_next   = root;
                    state_next = longer_reg ? ST_MUL_X : ST_ADV;
                end
            end
            ST_ADV: begin
                rem_next   = rem_reg - STEP_W'(len_reg);
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
                state_next = ST_LOOP;
            end
            ST_MUL_X: begin
                mul_a      = ux_reg;
                mul_b      = rem_reg[31:0];
                state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (!div_stat.busy && !div_stat.done) begin
                    div_start = 1'b1;
                end
                if (div_stat.done) begin
                    qx_next    = quot;
                    state_next = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                mul_a      = uy_reg;
                mul_b      = rem_reg[31:0];
                state_next = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                mul_a = uy_reg;
                mul_b = rem_reg[31:0];
                // The product of the previous cycle is the dividend.
                if (!div_stat.busy && !div_stat.done) begin
                    div_start = 1'b1;
                end
                if (div_stat.done) begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{lng: new_lng[LNG_W-1:0], lat: new_lat[LAT_W-1:0]};
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                state_next = ST_HEAD_W;
            end
            ST_HEAD_W: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, ovf_reg, arrived_reg, cnt_ext[6:0],
                                    (count_reg != '0) ? rdata_reg.lat : LAT_W'(0),
                                    (count_reg != '0) ? rdata_reg.lng : LNG_W'(0)};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            arrived_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            speed_reg   <= '0;
            tstep_reg   <= TIME_STEP_RESET;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            arrived_reg <= arrived_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SPEED:     speed_reg <= cfg_wdata;
                    REG_TIME_STEP: tstep_reg <= cfg_wdata[23:0];
                    default:       speed_reg <= speed_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        mode_reg   <= mode_next;
        pt_reg     <= pt_next;
        a_reg      <= a_next;
        ovf_reg    <= ovf_next;
        xneg_reg   <= xneg_next;
        yneg_reg   <= yneg_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        d2_reg     <= d2_next;
        rem_reg    <= rem_next;
        len_reg    <= len_next;
        longer_reg <= longer_next;
        qx_reg     <= qx_next;
    end

    // Path store ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The queue never holds more than its depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PATH_DEPTH))
        else $error("point count beyond depth");

    // Passing a segment never makes the remaining step grow.
    a_rem_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADV |=> rem_reg <= $past(rem_reg))
        else $error("remaining step grew");

    // A tick that runs out of segments leaves the arrived flag set.
    a_arrive: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOP && count_reg < CNT_W'(2) |=> arrived_reg)
        else $error("arrived flag not set");

    // The queue stays untouched while waiting for a beat.
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue changed while idle");

endmodule

// ===== hw/rtl/pf_mul.sv =====
// Registered 32 x 32 unsigned multiplier shared by every product of the block.
// Depends on nothing but the clock.
module pf_mul (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // One product per cycle, ready at the next edge.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/pf_isqrt.sv =====
// Iterative integer square root of a 64-bit value, two radicand bits a cycle.
// Depends on pf_pkg for the unit status struct.
module pf_isqrt
    import pf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output unit_stat_t  stat
);

    logic [63:0] n_reg, n_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] trial;

    // One digit-by-digit step of the root per cycle.
    always_comb begin
        trial     = res_reg + bit_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_next   = n_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root      = res_reg[31:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hw/rtl/pf_div.sv =====
// Restoring divider: 64-bit dividend by 32-bit divisor, quotient below 2^32.
// One quotient bit a cycle; depends on pf_pkg for the unit status struct.
module pf_div
    import pf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output unit_stat_t  stat
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // The upper half is already below the divisor, so 32 steps suffice.
    always_comb begin
        trial     = {rem_reg, lo_reg[31]};
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend[63:32];
            lo_next   = dividend[31:0];
            d_next    = divisor;
            q_next    = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = 32'(trial - {1'b0, d_reg});
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            lo_next  = {lo_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
